@@ hdl/lrqs_pkg.sv @@
// Shared constants, types and register codes for the largest-remainder
// quota split block. No dependencies; every other file but lrqs_fifo imports it.
`timescale 1ns / 1ps
package lrqs_pkg;

    localparam int NUM_SHARES   = 5;
    localparam int TOTAL_W      = 16;
    localparam int WEIGHT_W     = 7;
    localparam int SHARE_W      = 16;
    localparam int REM_W        = 7;
    localparam int REM0_W       = 8;
    localparam int PROD_W       = TOTAL_W + WEIGHT_W;
    localparam int SUM_W        = SHARE_W + 3;
    localparam int LEFT_W       = SUM_W + 1;
    localparam int RANK_W       = 3;
    localparam int CFG_IDX_W    = 3;

    // floor(x / 100) is taken as (x * RECIP_M) >> RECIP_SHIFT, then corrected
    // by at most one step; the estimate is never high for x below 2**23.
    localparam int RECIP_BITS   = 18;
    localparam int RECIP_SHIFT  = 24;
    localparam int MUL_W        = PROD_W + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_M = RECIP_BITS'((2 ** RECIP_SHIFT) / 100);

    localparam logic [WEIGHT_W-1:0] PERCENT_FULL = WEIGHT_W'(100);

    localparam int FRONT_STAGES  = 4;
    localparam int INFLIGHT_W    = 3;
    localparam int MID_DEPTH_DEF = 8;
    localparam int OUT_DEPTH_DEF = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZERO  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FOUR  = CFG_IDX_W'(4);

    typedef logic [NUM_SHARES-1:0][WEIGHT_W-1:0] t_weights;

    localparam t_weights WEIGHT_RESET = {
        WEIGHT_W'(10), WEIGHT_W'(10), WEIGHT_W'(10), WEIGHT_W'(10), WEIGHT_W'(60)
    };

    typedef struct packed {
        logic [NUM_SHARES-1:0][SHARE_W-1:0] floors;
        logic [NUM_SHARES-1:0][REM_W-1:0]   rems;
        logic [LEFT_W-1:0]                  left;
    } t_mid_item;

    typedef struct packed {
        logic [NUM_SHARES-1:0][SHARE_W-1:0] shares;
    } t_out_item;

    typedef struct packed {
        logic [INFLIGHT_W-1:0] inflight;
        logic                  out_valid;
    } t_front_status;

endpackage

@@ hdl/lrqs_fifo.sv @@
// Small first-in first-out queue in flip-flops, generic width and depth.
// No dependencies.
`timescale 1ns / 1ps
module lrqs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_wdata,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_rdata,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];

    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ hdl/lrqs_front.sv @@
// Front pipeline: weighted products, floors and remainders by 100, leftover.
// Depends on lrqs_pkg.
`timescale 1ns / 1ps
module lrqs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [lrqs_pkg::TOTAL_W-1:0]  i_total_units,
    input  lrqs_pkg::t_weights            i_weights,
    output lrqs_pkg::t_mid_item           o_item,
    output lrqs_pkg::t_front_status       o_status
);
    import lrqs_pkg::*;

    // Stage 1: products.
    logic                                r_s1_valid;
    logic [TOTAL_W-1:0]                  r_s1_total;
    logic [NUM_SHARES-1:0][PROD_W-1:0]   r_s1_prod, n_s1_prod;
    // Stage 2: quotient estimates.
    logic                                r_s2_valid;
    logic [TOTAL_W-1:0]                  r_s2_total;
    logic [NUM_SHARES-1:0][PROD_W-1:0]   r_s2_prod;
    logic [NUM_SHARES-1:0][SHARE_W-1:0]  r_s2_q0, n_s2_q0;
    // Stage 3: exact floors and remainders.
    logic                                r_s3_valid;
    logic [TOTAL_W-1:0]                  r_s3_total;
    logic [NUM_SHARES-1:0][SHARE_W-1:0]  r_s3_floor, n_s3_floor;
    logic [NUM_SHARES-1:0][REM_W-1:0]    r_s3_rem, n_s3_rem;
    // Stage 4: leftover.
    logic                                r_s4_valid;
    t_mid_item                           r_s4_item, n_s4_item;

    always_comb begin
        logic [WEIGHT_W-1:0] wc;
        logic [MUL_W-1:0]    mul;
        logic [PROD_W-1:0]   diff;
        logic [REM0_W-1:0]   r0;
        logic [SUM_W-1:0]    sum;
        sum = '0;
        for (int k = 0; k < NUM_SHARES; k++) begin
            // Weights above one hundred act as one hundred.
            wc = (i_weights[k] > PERCENT_FULL) ? PERCENT_FULL : i_weights[k];
            n_s1_prod[k] = PROD_W'(i_total_units) * PROD_W'(wc);

            mul = MUL_W'(r_s1_prod[k]) * MUL_W'(RECIP_M);
            n_s2_q0[k] = SHARE_W'(mul >> RECIP_SHIFT);

            diff = r_s2_prod[k] - PROD_W'(r_s2_q0[k]) * PROD_W'(PERCENT_FULL);
            r0   = diff[REM0_W-1:0];
            if (r0 >= REM0_W'(PERCENT_FULL)) begin
                n_s3_floor[k] = r_s2_q0[k] + SHARE_W'(1);
                n_s3_rem[k]   = REM_W'(r0 - REM0_W'(PERCENT_FULL));
            end else begin
                n_s3_floor[k] = r_s2_q0[k];
                n_s3_rem[k]   = REM_W'(r0);
            end

            sum = sum + SUM_W'(r_s3_floor[k]);
        end
        n_s4_item.floors = r_s3_floor;
        n_s4_item.rems   = r_s3_rem;
        n_s4_item.left   = LEFT_W'(r_s3_total) - LEFT_W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_total <= i_total_units;
        r_s1_prod  <= n_s1_prod;
        r_s2_total <= r_s1_total;
        r_s2_prod  <= r_s1_prod;
        r_s2_q0    <= n_s2_q0;
        r_s3_total <= r_s2_total;
        r_s3_floor <= n_s3_floor;
        r_s3_rem   <= n_s3_rem;
        r_s4_item  <= n_s4_item;
    end

    assign o_item             = r_s4_item;
    assign o_status.out_valid = r_s4_valid;
    assign o_status.inflight  = INFLIGHT_W'(r_s1_valid) + INFLIGHT_W'(r_s2_valid)
                              + INFLIGHT_W'(r_s3_valid) + INFLIGHT_W'(r_s4_valid);

endmodule

@@ hdl/lrqs_back.sv @@
// Back end: hands out leftover units by remainder rank and queues results.
// Depends on lrqs_pkg and lrqs_fifo.
`timescale 1ns / 1ps
module lrqs_back #(
    parameter int OUT_DEPTH = lrqs_pkg::OUT_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lrqs_pkg::t_mid_item    i_mid_item,
    input  logic                   i_mid_empty,
    output logic                   o_mid_pop,
    input  logic                   i_pop,
    output lrqs_pkg::t_out_item    o_out_item,
    output logic                   o_empty
);
    import lrqs_pkg::*;

    logic                               w_out_full;
    logic                               w_left_pos;
    logic [RANK_W-1:0]                  w_pos_cnt;
    logic [RANK_W-1:0]                  w_give_cnt;
    logic [LEFT_W-1:0]                  w_extra;
    logic [NUM_SHARES-1:0][RANK_W-1:0]  w_rank;
    t_out_item                          w_result;

    assign o_mid_pop = !i_mid_empty && !w_out_full;

    // Remainders rank by value, descending, the lower index first on a tie;
    // a share gets one unit when its rank is below the number handed out.
    always_comb begin
        w_left_pos = !i_mid_item.left[LEFT_W-1] && (i_mid_item.left != '0);
        w_pos_cnt  = '0;
        for (int k = 0; k < NUM_SHARES; k++) begin
            w_pos_cnt = w_pos_cnt + RANK_W'(i_mid_item.rems[k] != '0);
            w_rank[k] = '0;
            for (int j = 0; j < NUM_SHARES; j++) begin
                if (j != k) begin
                    if ((i_mid_item.rems[j] > i_mid_item.rems[k]) ||
                        ((i_mid_item.rems[j] == i_mid_item.rems[k]) && (j < k))) begin
                        w_rank[k] = w_rank[k] + RANK_W'(1);
                    end
                end
            end
        end

        if (!w_left_pos) begin
            w_give_cnt = '0;
            w_extra    = '0;
        end else if (i_mid_item.left > LEFT_W'(w_pos_cnt)) begin
            w_give_cnt = w_pos_cnt;
            w_extra    = i_mid_item.left - LEFT_W'(w_pos_cnt);
        end else begin
            w_give_cnt = i_mid_item.left[RANK_W-1:0];
            w_extra    = '0;
        end

        for (int k = 0; k < NUM_SHARES; k++) begin
            w_result.shares[k] = i_mid_item.floors[k] + SHARE_W'(
                (i_mid_item.rems[k] != '0) && (w_rank[k] < w_give_cnt));
        end
        // Units no remainder can place all go to share zero.
        w_result.shares[0] = w_result.shares[0] + SHARE_W'(w_extra);
    end

    lrqs_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_mid_pop),
        .i_wdata (w_result),
        .i_pop   (i_pop),
        .o_rdata (o_out_item),
        .o_empty (o_empty),
        .o_full  (w_out_full),
        .o_count ()
    );

endmodule

@@ hdl/largest_remainder_quota_split.sv @@
// Channel   Direction  Handshake                   Payload
// input     in         push / full                 i_total_units
// result    out        empty / pop                 o_share_zero .. o_share_four
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while full is low. Its result goes through
// the four front stages and the middle queue, then into the output queue (the
// allocation logic works combinationally on the middle queue head).
// Reset sets the weights to 60, 10, 10, 10, 10 and empties both queues.
// full rises once the middle queue plus the items in the front pipeline reach
// MID_DEPTH; the allocation stage waits while the output queue is full.
`timescale 1ns / 1ps
module largest_remainder_quota_split #(
    parameter int MID_DEPTH = lrqs_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = lrqs_pkg::OUT_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [lrqs_pkg::TOTAL_W-1:0]    i_total_units,
    output logic                            empty,
    input  logic                            pop,
    output logic [lrqs_pkg::SHARE_W-1:0]    o_share_zero,
    output logic [lrqs_pkg::SHARE_W-1:0]    o_share_one,
    output logic [lrqs_pkg::SHARE_W-1:0]    o_share_two,
    output logic [lrqs_pkg::SHARE_W-1:0]    o_share_three,
    output logic [lrqs_pkg::SHARE_W-1:0]    o_share_four,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lrqs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrqs_pkg::WEIGHT_W-1:0]   i_cfg_data
);
    import lrqs_pkg::*;

    localparam int MCW = $clog2(MID_DEPTH + 1);
    localparam int CRW = $clog2(MID_DEPTH + FRONT_STAGES + 1);

    t_weights        r_weights;
    logic            w_accept;
    t_mid_item       w_front_item;
    t_front_status   w_front_stat;
    t_mid_item       w_mid_head;
    logic            w_mid_empty;
    logic            w_mid_full;
    logic            w_mid_pop;
    logic [MCW-1:0]  w_mid_count;
    logic [CRW-1:0]  w_credit_used;
    t_out_item       w_out_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= WEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WEIGHT_ZERO:  r_weights[0] <= i_cfg_data;
                REG_WEIGHT_ONE:   r_weights[1] <= i_cfg_data;
                REG_WEIGHT_TWO:   r_weights[2] <= i_cfg_data;
                REG_WEIGHT_THREE: r_weights[3] <= i_cfg_data;
                REG_WEIGHT_FOUR:  r_weights[4] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front pipeline never stalls, so space is reserved in the middle
    // queue for every item still in flight.
    assign w_credit_used = CRW'(w_mid_count) + CRW'(w_front_stat.inflight);
    assign full          = (w_credit_used >= CRW'(MID_DEPTH));
    assign w_accept      = push && !full;

    lrqs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_total_units (i_total_units),
        .i_weights     (r_weights),
        .o_item        (w_front_item),
        .o_status      (w_front_stat)
    );

    lrqs_fifo #(
        .WIDTH ($bits(t_mid_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_stat.out_valid),
        .i_wdata (w_front_item),
        .i_pop   (w_mid_pop),
        .o_rdata (w_mid_head),
        .o_empty (w_mid_empty),
        .o_full  (w_mid_full),
        .o_count (w_mid_count)
    );

    lrqs_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_item  (w_mid_head),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_pop       (pop),
        .o_out_item  (w_out_item),
        .o_empty     (empty)
    );

    assign o_share_zero  = w_out_item.shares[0];
    assign o_share_one   = w_out_item.shares[1];
    assign o_share_two   = w_out_item.shares[2];
    assign o_share_three = w_out_item.shares[3];
    assign o_share_four  = w_out_item.shares[4];

    a_mid_no_overflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_front_stat.out_valid |-> !w_mid_full
    ) else $error("front pipeline delivered an item into a full middle queue");

    a_credit_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_credit_used <= CRW'(MID_DEPTH)
    ) else $error("middle queue reservations exceed its depth");

    a_accept_enters_front: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_front_stat.inflight != '0)
    ) else $error("accepted item did not enter the front pipeline");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for largest_remainder_quota_split: weight settings, totals and
// random idling on both queue sides, each result checked against a model of the split.
// Depends on lrqs_pkg and the block's top level only.
`timescale 1ns / 1ps
module tb;
    import lrqs_pkg::*;

    typedef logic [NUM_SHARES-1:0][SHARE_W-1:0] t_shares;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        t_shares            shares;
    } t_split;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(NUM_SHARES);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX      = '1;

    localparam int PHASE_ITEMS  = 235;
    localparam int RAND_PHASES  = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int DRAIN_LIMIT  = 20000;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 push          = 1'b0;
    logic                 pop           = 1'b0;
    logic [TOTAL_W-1:0]   i_total_units = '0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [WEIGHT_W-1:0]  i_cfg_data    = '0;

    logic                 full;
    logic                 empty;
    logic                 o_cfg_ready;
    logic [SHARE_W-1:0]   o_share_zero;
    logic [SHARE_W-1:0]   o_share_one;
    logic [SHARE_W-1:0]   o_share_two;
    logic [SHARE_W-1:0]   o_share_three;
    logic [SHARE_W-1:0]   o_share_four;

    logic [TOTAL_W-1:0]   pending_totals [$];
    t_split               split_expect_q [$];
    t_weights             weight_mirror = WEIGHT_RESET;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   mismatch_count = 0;
    t_split               accepted_split;
    t_split               wanted_split;
    t_shares              got_shares;

    largest_remainder_quota_split u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_total_units (i_total_units),
        .empty         (empty),
        .pop           (pop),
        .o_share_zero  (o_share_zero),
        .o_share_one   (o_share_one),
        .o_share_two   (o_share_two),
        .o_share_three (o_share_three),
        .o_share_four  (o_share_four),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Hamilton split: floors first, then one unit per positive remainder in
    // descending order, and whatever is still left goes to share zero.
    function automatic t_shares apportion_total(input logic [TOTAL_W-1:0] total,
                                                input t_weights w);
        int unsigned part [NUM_SHARES];
        int unsigned rem [NUM_SHARES];
        int unsigned wt;
        int unsigned prod;
        int unsigned floor_sum;
        int          left;
        int          best;
        t_shares     res;
        floor_sum = 0;
        for (int k = 0; k < NUM_SHARES; k++) begin
            wt = w[k];
            if (wt > PERCENT_FULL)
                wt = PERCENT_FULL;
            prod = total * wt;
            part[k] = prod / PERCENT_FULL;
            rem[k] = prod % PERCENT_FULL;
            floor_sum += part[k];
        end
        left = int'(total) - int'(floor_sum);
        for (int pass = 0; pass < NUM_SHARES && left > 0; pass++) begin
            best = 0;
            for (int k = 1; k < NUM_SHARES; k++) begin
                if (rem[k] > rem[best])
                    best = k;
            end
            if (rem[best] == 0)
                break;
            part[best] += 1;
            rem[best] = 0;
            left--;
        end
        if (left > 0)
            part[0] += left;
        for (int k = 0; k < NUM_SHARES; k++)
            res[k] = part[k][SHARE_W-1:0];
        return res;
    endfunction

    // Sender side: an item stays on the port until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                accepted_split.total = pending_totals.pop_front();
                accepted_split.shares = apportion_total(accepted_split.total, weight_mirror);
                split_expect_q.push_back(accepted_split);
            end
            if (!(push && full)) begin
                if (pending_totals.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    push <= 1'b1;
                    i_total_units <= pending_totals[0];
                end else begin
                    push <= 1'b0;
                    i_total_units <= TOTAL_W'($urandom);
                end
            end
        end
    end

    // Receiver side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got_shares = {o_share_four, o_share_three, o_share_two, o_share_one,
                              o_share_zero};
                if (split_expect_q.size() == 0) begin
                    report_mismatch("result arrived with no item outstanding");
                end else begin
                    wanted_split = split_expect_q.pop_front();
                    for (int k = 0; k < NUM_SHARES; k++) begin
                        if (got_shares[k] !== wanted_split.shares[k])
                            report_mismatch($sformatf("total %0d share %0d: got %0d, want %0d",
                                wanted_split.total, k, got_shares[k],
                                wanted_split.shares[k]));
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IDX_W'($urandom);
        i_cfg_data <= WEIGHT_W'($urandom);
        if (idx < NUM_SHARES)
            weight_mirror[idx] = val;
    endtask

    task automatic set_weights(input t_weights w);
        write_reg(REG_WEIGHT_ZERO, w[0]);
        write_reg(REG_WEIGHT_ONE, w[1]);
        write_reg(REG_WEIGHT_TWO, w[2]);
        write_reg(REG_WEIGHT_THREE, w[3]);
        write_reg(REG_WEIGHT_FOUR, w[4]);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Waits until every item has been taken and every result has come back.
    task automatic wait_idle();
        int waited;
        waited = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while ((pending_totals.size() != 0 || push || split_expect_q.size() != 0)
                   && waited < DRAIN_LIMIT);
        if (pending_totals.size() != 0 || split_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d items not taken, %0d results missing",
                pending_totals.size(), split_expect_q.size()));
            split_expect_q.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_totals(input logic [TOTAL_W-1:0] totals [$]);
        @(negedge i_clk);
        foreach (totals[k])
            pending_totals.push_back(totals[k]);
        wait_idle();
    endtask

    function automatic logic [TOTAL_W-1:0] random_total();
        case ($urandom_range(9))
            0: return TOTAL_W'($urandom_range(99));
            1: return TOTAL_W'(65535 - $urandom_range(99));
            2: return TOTAL_W'($urandom_range(655) * 100);
            default: return TOTAL_W'($urandom);
        endcase
    endfunction

    // Mostly weights that sum to one hundred or less, sometimes raw register values.
    task automatic random_weights();
        t_weights w;
        int       budget;
        int       rot;
        int       pick;
        rot = $urandom_range(NUM_SHARES - 1);
        case ($urandom_range(3))
            0, 1: budget = PERCENT_FULL;
            2: budget = $urandom_range(PERCENT_FULL - 1);
            default: budget = -1;
        endcase
        for (int k = 0; k < NUM_SHARES; k++) begin
            if (budget < 0) begin
                w[k] = WEIGHT_W'($urandom_range(WEIGHT_MAX));
            end else begin
                pick = (k == NUM_SHARES - 1) ? budget : $urandom_range(budget);
                w[(k + rot) % NUM_SHARES] = WEIGHT_W'(pick);
                budget -= pick;
            end
        end
        set_weights(w);
        if ($urandom_range(1))
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                      WEIGHT_W'($urandom));
    endtask

    initial begin
        logic [TOTAL_W-1:0] totals [$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0, 0);

        // Reset weights, then field extremes.
        totals = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd101, 16'd65535, 16'd12345};
        queue_totals(totals);

        // Equal remainders: lower index is served first.
        set_weights({7'd20, 7'd20, 7'd20, 7'd20, 7'd20});
        totals = '{16'd3, 16'd4, 16'd1, 16'd65534};
        queue_totals(totals);

        // Weights above one hundred are clamped; the sum overshoots and the
        // leftover goes negative.
        set_weights({7'd0, 7'd0, 7'd101, 7'd100, WEIGHT_MAX});
        totals = '{16'd65535, 16'd99, 16'd1};
        queue_totals(totals);

        // All weights zero: everything lands in share zero.
        set_weights({7'd0, 7'd0, 7'd0, 7'd0, 7'd0});
        totals = '{16'd65535, 16'd5};
        queue_totals(totals);

        // Sum below one hundred, plus writes to unused indexes that must be ignored.
        set_weights({7'd0, 7'd0, 7'd33, 7'd33, 7'd33});
        write_reg(REG_SPARE_FIRST, WEIGHT_MAX);
        write_reg(REG_SPARE_LAST, 7'd0);
        totals = '{16'd1, 16'd2, 16'd100, 16'd65535};
        queue_totals(totals);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(57, 0);
                2: set_idling(0, 57);
                default: set_idling(10, 10);
            endcase
            if (p == RAND_PHASES - 1)
                set_weights({WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX});
            else
                random_weights();
            totals.delete();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                totals.push_back(random_total());
                // Halfway through one phase the sender holds off until the block drains.
                if (p == 5 && k == PHASE_ITEMS / 2) begin
                    queue_totals(totals);
                    totals.delete();
                end
            end
            queue_totals(totals);
        end

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
